// ===== src/grc_pkg.sv =====
// Shared types, constants and a helper function for the grid raycaster.
package grc_pkg;

  localparam int MapDim  = 32;
  localparam int MapBits = 5;
  localparam int CellCnt = MapDim * MapDim;
  localparam int Rows    = 32;
  localparam int DistW   = 24;
  localparam int DvdW    = 30;
  localparam int WalkMax = 2 * MapDim + 4;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [2:0] {
    REG_CAM_X   = 3'd0,
    REG_CAM_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_t;

  // Wall character for a wall type; the y-side face gets the shaded set.
  function automatic logic [6:0] glyph_of(input logic [2:0] typ, input logic side);
    logic [6:0] c;
    begin
      case (typ)
        3'd1:    c = side ? 7'h2E : 7'h23;
        3'd2:    c = side ? 7'h2C : 7'h40;
        3'd3:    c = side ? 7'h27 : 7'h24;
        3'd4:    c = side ? 7'h2D : 7'h3D;
        3'd5:    c = side ? 7'h2B : 7'h2A;
        default: c = 7'h20;
      endcase
      return c;
    end
  endfunction

endpackage

// ===== src/grid_raycast_column_core.sv =====
// Top level of the grid raycaster: map store, shared divider and DDA sequencer.
// A map write does not make the block busy. A cast walks n cells (at most 68) and
// runs the shared 30-step divider for both ray deltas and then for the wall height.
// One item is worked at a time; busy stays high until the result strobe.
// After reset the map is cleared one cell a cycle: busy is high until all 1024 are clear.
// The receiver cannot stall: out_valid is high for exactly one cycle per cast.
module grid_raycast_column_core
  import grc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [5:0]  in_column,
  input  logic [4:0]  in_cell_row,
  input  logic [4:0]  in_cell_col,
  input  logic [2:0]  in_cell_value,
  output logic        out_valid,
  output logic [5:0]  out_column,
  output logic [4:0]  out_span_top,
  output logic [4:0]  out_span_bottom,
  output logic [6:0]  out_wall_char,
  output logic        out_hit_side,
  output logic [2:0]  out_hit_type,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_RAY   = 10'b0000000100,
    S_DIVX  = 10'b0000001000,
    S_DIVY  = 10'b0000010000,
    S_SX    = 10'b0000100000,
    S_SY    = 10'b0001000000,
    S_STEP  = 10'b0010000000,
    S_CHECK = 10'b0100000000,
    S_DIVH  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [12:0]        cam_x_r, cam_y_r;
  logic signed [14:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  // Map store.
  logic [2:0]         grid_mem [CellCnt];
  logic [9:0]         clr_cnt_r;
  logic [2:0]         rdata_r;
  logic               mem_we;
  logic [9:0]         mem_waddr;
  logic [2:0]         mem_wdata;
  logic [9:0]         mem_raddr;

  // Cast working state.
  logic [5:0]         col_r;
  logic signed [16:0] rx_r, ry_r;
  logic [DistW-1:0]   dx_r, dy_r, sx_r, sy_r, perp_r;
  logic signed [7:0]  mx_r, my_r;
  logic               side_r, oob_r;
  logic [6:0]         n_r;
  logic [2:0]         type_r;

  // Shared divider.
  logic [DvdW-1:0]    dvd_r, dvd_nxt;
  logic [DistW-1:0]   dsr_r, rem_r, rem_nxt;
  logic [DistW:0]     rem_sh;
  logic               rem_ge;
  logic [4:0]         div_cnt_r;
  logic               div_last;
  logic [DistW-1:0]   q_sat;

  // Shared multiplier for the start distances.
  logic [8:0]         mul_a;
  logic [DistW-1:0]   mul_b;
  logic [32:0]        mul_p;
  logic [DistW-1:0]   mul_sat;

  logic               in_acc, cfg_wr;
  logic signed [8:0]  cam;
  logic signed [23:0] prod_x, prod_y;
  logic signed [17:0] rx_sum, ry_sum;
  logic [15:0]        mag_x, mag_y;
  logic               step_x;
  logic [DistW:0]     sum_d;
  logic signed [7:0]  mx_nxt, my_nxt;
  logic [2:0]         cell_typ;
  logic               walk_end;
  logic [20:0]        half_h;

  assign pready = 1'b1;
  assign busy   = (state_r != S_IDLE);
  assign in_acc = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_CAM_X:   prdata = {19'd0, cam_x_r};
      REG_CAM_Y:   prdata = {19'd0, cam_y_r};
      REG_DIR_X:   prdata = {17'd0, dir_x_r};
      REG_DIR_Y:   prdata = {17'd0, dir_y_r};
      REG_PLANE_X: prdata = {17'd0, plane_x_r};
      REG_PLANE_Y: prdata = {17'd0, plane_y_r};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= 13'd512;
      cam_y_r   <= 13'd512;
      dir_x_r   <= -15'sd8192;
      dir_y_r   <= 15'sd0;
      plane_x_r <= 15'sd0;
      plane_y_r <= 15'sd5407;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_CAM_X:   cam_x_r   <= pwdata[12:0];
        REG_CAM_Y:   cam_y_r   <= pwdata[12:0];
        REG_DIR_X:   dir_x_r   <= $signed(pwdata[14:0]);
        REG_DIR_Y:   dir_y_r   <= $signed(pwdata[14:0]);
        REG_PLANE_X: plane_x_r <= $signed(pwdata[14:0]);
        REG_PLANE_Y: plane_y_r <= $signed(pwdata[14:0]);
        default: ;
      endcase
    end
  end

  // Map store: the clearing pass and map writes share the write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {in_cell_row, in_cell_col};
    mem_wdata = in_cell_value;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = 3'd0;
    end else if (in_acc && op_t'(in_operation) == OP_WRITE && in_cell_value <= 3'd5) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= grid_mem[mem_raddr];
  end

  // Ray components: dir + floor(plane * (2*column - COLS) / COLS).
  assign cam    = $signed({2'b00, col_r, 1'b0}) - 9'sd64;
  assign prod_x = plane_x_r * cam;
  assign prod_y = plane_y_r * cam;
  assign rx_sum = 18'(dir_x_r) + 18'(prod_x >>> 6);
  assign ry_sum = 18'(dir_y_r) + 18'(prod_y >>> 6);
  assign mag_x  = rx_r[16] ? 16'(-rx_r) : rx_r[15:0];
  assign mag_y  = ry_r[16] ? 16'(-ry_r) : ry_r[15:0];

  // One restoring division step per cycle; a zero divisor saturates.
  assign rem_sh   = {rem_r, dvd_r[DvdW-1]};
  assign rem_ge   = rem_sh >= {1'b0, dsr_r};
  assign rem_nxt  = rem_ge ? DistW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DistW-1:0];
  assign dvd_nxt  = {dvd_r[DvdW-2:0], rem_ge};
  assign div_last = (div_cnt_r == 5'(DvdW - 1));
  assign q_sat    = (dvd_nxt[DvdW-1:DistW] != '0) ? DistMax : dvd_nxt[DistW-1:0];

  // Start distance: fraction (or its complement) times delta, over 256.
  always_comb begin
    if (state_r == S_SX) begin
      mul_a = rx_r[16] ? {1'b0, cam_x_r[7:0]} : 9'd256 - {1'b0, cam_x_r[7:0]};
      mul_b = dx_r;
    end else begin
      mul_a = ry_r[16] ? {1'b0, cam_y_r[7:0]} : 9'd256 - {1'b0, cam_y_r[7:0]};
      mul_b = dy_r;
    end
  end
  assign mul_p   = mul_a * mul_b;
  assign mul_sat = (mul_p[32] != 1'b0) ? DistMax : mul_p[31:8];

  // DDA step; a tie goes to y.
  assign step_x = sx_r < sy_r;
  assign sum_d  = step_x ? {1'b0, sx_r} + {1'b0, dx_r} : {1'b0, sy_r} + {1'b0, dy_r};
  assign mx_nxt = step_x ? (rx_r[16] ? mx_r - 8'sd1 : mx_r + 8'sd1) : mx_r;
  assign my_nxt = step_x ? my_r : (ry_r[16] ? my_r - 8'sd1 : my_r + 8'sd1);
  assign mem_raddr = {mx_nxt[MapBits-1:0], my_nxt[MapBits-1:0]};

  assign cell_typ = oob_r ? 3'd1 : rdata_r;
  assign walk_end = (cell_typ != 3'd0) || (n_r == 7'(WalkMax));
  assign half_h   = dvd_nxt[21:1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == 10'(CellCnt - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc && op_t'(in_operation) == OP_CAST) state_nxt = S_RAY;
      S_RAY:   state_nxt = S_DIVX;
      S_DIVX:  if (div_last) state_nxt = S_DIVY;
      S_DIVY:  if (div_last) state_nxt = S_SX;
      S_SX:    state_nxt = S_SY;
      S_SY:    state_nxt = S_STEP;
      S_STEP:  state_nxt = S_CHECK;
      S_CHECK: state_nxt = walk_end ? S_DIVH : S_STEP;
      S_DIVH:  if (div_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= 10'd0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 10'd1;
      end
      if (state_r == S_DIVH && div_last) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        col_r <= in_column;
      end
      S_RAY: begin
        rx_r      <= rx_sum[16:0];
        ry_r      <= ry_sum[16:0];
        mx_r      <= {3'b000, cam_x_r[12:8]};
        my_r      <= {3'b000, cam_y_r[12:8]};
        n_r       <= 7'd0;
        dvd_r     <= DvdW'(1) << 29;
        dsr_r     <= DistW'(rx_sum[16] ? 16'(-rx_sum[16:0]) : rx_sum[15:0]);
        rem_r     <= '0;
        div_cnt_r <= 5'd0;
      end
      S_DIVX: begin
        dvd_r     <= dvd_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_last) begin
          dx_r      <= q_sat;
          dvd_r     <= DvdW'(1) << 29;
          dsr_r     <= DistW'(mag_y);
          rem_r     <= '0;
          div_cnt_r <= 5'd0;
        end
      end
      S_DIVY: begin
        dvd_r     <= dvd_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_last) begin
          dy_r <= q_sat;
        end
      end
      S_SX: sx_r <= mul_sat;
      S_SY: sy_r <= mul_sat;
      S_STEP: begin
        perp_r <= step_x ? sx_r : sy_r;
        if (step_x) begin
          sx_r <= sum_d[DistW] ? DistMax : sum_d[DistW-1:0];
        end else begin
          sy_r <= sum_d[DistW] ? DistMax : sum_d[DistW-1:0];
        end
        mx_r   <= mx_nxt;
        my_r   <= my_nxt;
        side_r <= !step_x;
        n_r    <= n_r + 7'd1;
        oob_r  <= mx_nxt < 0 || my_nxt < 0 || mx_nxt >= 8'sd32 || my_nxt >= 8'sd32;
      end
      S_CHECK: begin
        if (walk_end) begin
          type_r    <= (cell_typ == 3'd0 || cell_typ > 3'd5) ? 3'd1 : cell_typ;
          dvd_r     <= DvdW'(Rows) << 16;
          dsr_r     <= perp_r;
          rem_r     <= '0;
          div_cnt_r <= 5'd0;
        end
      end
      S_DIVH: begin
        dvd_r     <= dvd_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_last) begin
          out_column    <= col_r;
          out_hit_side  <= side_r;
          out_hit_type  <= type_r;
          out_wall_char <= glyph_of(type_r, side_r);
          if (perp_r == '0) begin
            out_span_top    <= 5'd0;
            out_span_bottom <= 5'(Rows - 1);
          end else begin
            out_span_top    <= (half_h >= 21'(Rows / 2)) ? 5'd0 : 5'(21'(Rows / 2) - half_h);
            out_span_bottom <= (half_h >= 21'(Rows / 2 - 1)) ? 5'(Rows - 1)
                                                              : 5'(21'(Rows / 2) + half_h);
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/grc_checker.sv =====
// Port-level checker for the grid raycaster, bound to the top level.
module grc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_operation,
  input logic       out_valid,
  input logic [4:0] out_span_top,
  input logic [4:0] out_span_bottom
);

  // Reset starts the clearing pass, so the block is busy right after.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation) |=> busy)
    else $error("cast did not occupy the block");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_operation) |=> !busy)
    else $error("map write held the block");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_top <= out_span_bottom)
    else $error("wall span top below bottom");

endmodule

bind grid_raycast_column_core grc_checker u_grc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_span_top    (out_span_top),
  .out_span_bottom (out_span_bottom)
);
